// ===== hw/rtl/rau_pkg.sv =====
// Package with shared constants, opcodes and types of the rational arithmetic unit.
`timescale 1ns / 1ps
package rau_pkg;
	localparam int WORD_BITS_DEF = 32;
	localparam int NUM_W = 32;
	localparam int DEN_W = 31;

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_NEG = 3'd4;
	localparam logic [2:0] OP_RCP = 3'd5;
	localparam logic [2:0] OP_CMP = 3'd6;
	localparam logic [2:0] OP_NOP = 3'd7;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_OVF = 2'd2;

	typedef struct packed {
		logic [2:0] req_type;
		logic [31:0] a_num;
		logic [31:0] a_den;
		logic [31:0] b_num;
		logic [31:0] b_den;
	} req_t;

	typedef struct packed {
		logic [31:0] res_num;
		logic [30:0] res_den;
		logic [1:0] status;
		logic is_equal;
	} res_t;
endpackage

// ===== hw/rtl/rau_if.sv =====
// Valid/ready channel interface carrying one payload.
`timescale 1ns / 1ps
interface rau_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/rau_divider.sv =====
// Shared 64-bit restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module rau_divider (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [63:0] dividend,
	input logic [63:0] divisor,
	output logic done,
	output logic [63:0] quot,
	output logic [63:0] rem
);
	logic [6:0] cnt_q;
	logic busy_q;
	logic [63:0] q_q;
	logic [63:0] r_q;
	logic [63:0] d_q;
	logic [64:0] shifted;
	logic [64:0] diff;

	assign shifted = {r_q, q_q[63]};
	assign diff = shifted - {1'b0, d_q};

	// One shift and trial subtract per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			if (!diff[64]) begin
				r_q <= diff[63:0];
				q_q <= {q_q[62:0], 1'b1};
			end else begin
				r_q <= shifted[63:0];
				q_q <= {q_q[62:0], 1'b0};
			end
		end
	end

	assign quot = q_q;
	assign rem = r_q;
endmodule

// ===== hw/rtl/rational_arithmetic_unit_top.sv =====
// Top level of the rational arithmetic unit: sequencer around a shared divider.
//
// Channel | Dir | Payload
// req     | in  | req_type, a_num, a_den, b_num, b_den
// res     | out | res_num, res_den, status, is_equal
//
// A two-operand request forms its products in S_PROD1, S_PROD2 and S_COMB, then the Euclid
// gcd loop and two reductions run on the shared divider. Compare answers are registered
// in S_COMB; error and unused codes answer at once, registered on acceptance.
// Reset clears the sequencer and the result valid flag. A held result blocks
// the next request only until it is taken; the input is not ready while busy.
`timescale 1ns / 1ps
module rational_arithmetic_unit_top #(
	parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	rau_if.sink req,
	rau_if.source res
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_PROD1 = 4'd1;
	localparam logic [3:0] S_PROD2 = 4'd2;
	localparam logic [3:0] S_COMB = 4'd3;
	localparam logic [3:0] S_GCD = 4'd4;
	localparam logic [3:0] S_GWAIT = 4'd5;
	localparam logic [3:0] S_RN = 4'd6;
	localparam logic [3:0] S_RNW = 4'd7;
	localparam logic [3:0] S_RD = 4'd8;
	localparam logic [3:0] S_RDW = 4'd9;
	localparam logic [3:0] S_FIN = 4'd10;
	localparam logic [3:0] S_OUT = 4'd11;
	localparam logic [63:0] HALF = 64'd1 << (WORD_BITS - 1);

	logic [3:0] state_q;
	logic [2:0] op_q;
	logic an_q, bn_q;
	logic [31:0] amag_q, adm_q, bmag_q, bdm_q;
	logic [63:0] t1_q, t2_q, n_q, d_q, x_q, y_q;
	logic neg_q;
	logic [31:0] mul_a, mul_b;
	logic [63:0] prod;
	logic [31:0] ma, mad, mb, mbd;
	logic sa, sad, sb, sbd;
	logic req_err;
	logic div_start, div_done;
	logic [63:0] div_n, div_d, div_q, div_r;
	rau_pkg::res_t out_q;
	logic out_v_q;

	// Read the low WORD_BITS bits of a field as a signed word; return magnitude.
	function automatic logic [31:0] mag_of(input logic [31:0] raw, output logic s);
		logic [31:0] u;
		u = raw & ((32'd1 << (WORD_BITS - 1)) * 32'd2 - 32'd1);
		s = u[WORD_BITS - 1];
		mag_of = s ? (((32'd1 << (WORD_BITS - 1)) * 32'd2) - u) : u;
	endfunction

	always_comb begin
		ma = mag_of(req.data.a_num, sa);
		mad = mag_of(req.data.a_den, sad);
		mb = mag_of(req.data.b_num, sb);
		mbd = mag_of(req.data.b_den, sbd);
	end

	// A zero denominator or a division by zero answers at once.
	assign req_err = mad == 32'd0 || ((req.data.req_type <= rau_pkg::OP_DIV
		|| req.data.req_type == rau_pkg::OP_CMP) && mbd == 32'd0)
		|| (req.data.req_type == rau_pkg::OP_DIV && mb == 32'd0)
		|| (req.data.req_type == rau_pkg::OP_RCP && ma == 32'd0);

	// The single 32x32 multiplier, operands chosen by the sequencer.
	assign prod = {32'd0, mul_a} * {32'd0, mul_b};
	always_comb begin
		mul_a = amag_q;
		mul_b = bdm_q;
		unique case (state_q)
			S_PROD1: begin
				mul_a = amag_q;
				mul_b = (op_q == rau_pkg::OP_MUL) ? bmag_q : bdm_q;
			end
			S_PROD2: begin
				mul_a = (op_q == rau_pkg::OP_DIV) ? adm_q : bmag_q;
				mul_b = (op_q == rau_pkg::OP_DIV) ? bmag_q : adm_q;
			end
			S_COMB: begin
				mul_a = adm_q;
				mul_b = bdm_q;
			end
			default: begin
				mul_a = amag_q;
				mul_b = bdm_q;
			end
		endcase
	end

	assign div_start = (state_q == S_GCD && y_q != 64'd0) || state_q == S_RN
		|| state_q == S_RD;
	assign div_n = (state_q == S_GCD) ? x_q : (state_q == S_RN) ? n_q : d_q;
	assign div_d = (state_q == S_GCD) ? y_q : x_q;

	rau_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_n),
		.divisor(div_d), .done(div_done), .quot(div_q), .rem(div_r)
	);

	assign req.ready = (state_q == S_IDLE) && !out_v_q;
	assign res.valid = out_v_q;
	assign res.data = out_q;

	// Sequencer: products, combine or compare, Euclid loop, reduce, range check.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_v_q <= 1'b0;
		end else begin
			if (res.valid && res.ready) out_v_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (req.valid && req.ready) begin
					if (req.data.req_type == rau_pkg::OP_NOP || req_err) begin
						out_v_q <= 1'b1;
					end else if (req.data.req_type == rau_pkg::OP_NEG
						|| req.data.req_type == rau_pkg::OP_RCP) begin
						state_q <= S_GCD;
					end else begin
						state_q <= S_PROD1;
					end
				end
				S_PROD1: state_q <= S_PROD2;
				S_PROD2: state_q <= S_COMB;
				S_COMB: begin
					if (op_q == rau_pkg::OP_CMP) begin
						out_v_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_GCD;
					end
				end
				S_GCD: state_q <= (y_q == 64'd0) ? S_RN : S_GWAIT;
				S_GWAIT: if (div_done) state_q <= S_GCD;
				S_RN: state_q <= S_RNW;
				S_RNW: if (div_done) state_q <= S_RD;
				S_RD: state_q <= S_RDW;
				S_RDW: if (div_done) state_q <= S_FIN;
				S_FIN: begin
					out_v_q <= 1'b1;
					state_q <= S_OUT;
				end
				S_OUT: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (req.valid && req.ready) begin
				op_q <= req.data.req_type;
				amag_q <= ma; adm_q <= mad; bmag_q <= mb; bdm_q <= mbd;
				an_q <= (sa != sad) && ma != 32'd0;
				bn_q <= (sb != sbd) && mb != 32'd0;
				if (req.data.req_type == rau_pkg::OP_NOP) begin
					out_q <= '0;
				end else if (req_err) begin
					out_q <= '{res_num: '0, res_den: '0, status: rau_pkg::ST_ZERO,
						is_equal: 1'b0};
				end
				if (req.data.req_type == rau_pkg::OP_NEG) begin
					neg_q <= !((sa != sad) && ma != 32'd0);
					n_q <= {32'd0, ma}; d_q <= {32'd0, mad};
					x_q <= {32'd0, ma}; y_q <= {32'd0, mad};
				end else begin
					neg_q <= (sa != sad) && ma != 32'd0;
					n_q <= {32'd0, mad}; d_q <= {32'd0, ma};
					x_q <= {32'd0, mad}; y_q <= {32'd0, ma};
				end
			end
			S_PROD1: t1_q <= prod;
			S_PROD2: t2_q <= prod;
			S_COMB: begin
				if (op_q == rau_pkg::OP_CMP) begin
					out_q <= '{res_num: '0, res_den: '0, status: rau_pkg::ST_OK,
						is_equal: (an_q == bn_q) && (t1_q == t2_q)};
				end else if (op_q == rau_pkg::OP_MUL || op_q == rau_pkg::OP_DIV) begin
					neg_q <= an_q != bn_q;
					n_q <= t1_q;
					x_q <= t1_q;
					d_q <= (op_q == rau_pkg::OP_DIV) ? t2_q : prod;
					y_q <= (op_q == rau_pkg::OP_DIV) ? t2_q : prod;
				end else begin
					logic s2;
					s2 = (op_q == rau_pkg::OP_SUB) ? (!bn_q && bmag_q != 32'd0) : bn_q;
					d_q <= prod; y_q <= prod;
					if (an_q == s2) begin
						neg_q <= an_q; n_q <= t1_q + t2_q; x_q <= t1_q + t2_q;
					end else if (t1_q >= t2_q) begin
						neg_q <= an_q; n_q <= t1_q - t2_q; x_q <= t1_q - t2_q;
					end else begin
						neg_q <= s2; n_q <= t2_q - t1_q; x_q <= t2_q - t1_q;
					end
				end
			end
			S_GWAIT: if (div_done) begin
				x_q <= y_q; y_q <= div_r;
			end
			S_RNW: if (div_done) n_q <= div_q;
			S_RDW: if (div_done) d_q <= div_q;
			S_FIN: begin
				if (n_q == 64'd0) begin
					out_q <= '{res_num: '0, res_den: 31'd1, status: rau_pkg::ST_OK,
						is_equal: 1'b0};
				end else if (d_q > HALF - 64'd1 || n_q > (neg_q ? HALF : HALF - 64'd1)) begin
					out_q <= '{res_num: '0, res_den: '0, status: rau_pkg::ST_OVF,
						is_equal: 1'b0};
				end else begin
					out_q <= '{res_num: neg_q ? (32'd0 - n_q[31:0]) : n_q[31:0],
						res_den: d_q[30:0], status: rau_pkg::ST_OK, is_equal: 1'b0};
				end
			end
			default: ;
		endcase
	end
endmodule

// ===== hw/rtl/rau_checker.sv =====
// Port-level checker for the rational arithmetic unit, bound to the top level.
`timescale 1ns / 1ps
module rau_port_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input rau_pkg::res_t out_data
);
	// A held result stays put until taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result dropped or changed while stalled");
	// No new request while a result waits.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("request taken while result pending");
	// Error results carry zero fields.
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != rau_pkg::ST_OK |-> out_data.res_den == '0
		&& out_data.res_num == '0 && !out_data.is_equal)
		else $error("error result with nonzero fields");
	// Status never takes the unused code.
	a_st: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.status <= rau_pkg::ST_OVF) else $error("bad status code");
endmodule

bind rational_arithmetic_unit_top rau_port_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(req.valid), .in_ready(req.ready),
	.out_valid(res.valid), .out_ready(res.ready), .out_data(res.data)
);
